FILE: rtl/fed_pkg.sv
// Shared constants and types of the damped feedback echo.
`default_nettype none

package fed_pkg;

  // Defaults of the top-level parameters.
  localparam int DELAY_DEPTH_DEF = 65536;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 2'd2;

  localparam logic [CFG_W-1:0] DELAY_RST = 16'd11025;
  localparam logic [CFG_W-1:0] GAIN_RST  = 16'd16384;
  localparam logic [CFG_W-1:0] DAMP_RST  = 16'd32768;

  // Unity in Q1.15.
  localparam logic [CFG_W-1:0] ONE_Q15 = 16'd32768;

  // Feedback modulation width.
  localparam int MOD_W = 16;

  // Shared multiplier: signed operands, full-width product.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Rounding shifts of the gain term and of the low-pass.
  localparam int GAIN_SHIFT = 30;
  localparam int LP_SHIFT   = 15;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

FILE: rtl/fed_in_if.sv
// Input channel: one audio sample and one feedback modulation value per transfer.
`default_nettype none

interface fed_in_if #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_BITS-1:0]  sample_in;
  logic signed [fed_pkg::MOD_W-1:0] feedback_mod;

  modport source (output valid, output sample_in, output feedback_mod, input ready);
  modport sink   (input valid, input sample_in, input feedback_mod, output ready);
endinterface

`default_nettype wire

FILE: rtl/fed_out_if.sv
// Result channel: one echo output sample per transfer.
`default_nettype none

interface fed_out_if #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/fed_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module fed_mul (
  input  logic                               clk,
  input  fed_pkg::mul_req_t                  req,
  output logic signed [fed_pkg::PROD_W-1:0]  p_r
);
  import fed_pkg::*;

  // The product holds while no request is issued.
  always_ff @(posedge clk) begin
    if (req.en) begin
      p_r <= req.a * req.b;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fed_ram.sv
// Delay line storage: one write port and one registered read port.
`default_nettype none

module fed_ram #(
  parameter int  DEPTH = 65536,
  parameter int  WIDTH = 24,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/feedback_echo_damped_unit.sv
// Top level of the damped feedback echo: sequencer, datapath and delay storage.
`default_nettype none

// One channel of feedback echo with a one-pole low-pass in the feedback path.
// After an input transfer the block stays busy, so no new item is taken until
// the previous one has been written back: four passes through the single
// shared 33 x 33 multiplier (gain, gain term, two low-pass products), a step
// for the saturated difference and one for the write-back into the delay
// line. The result is offered from an output register once the gain, product
// and difference steps are done; the next input is taken while it waits, and
// only a result still untaken when the following one is due holds the
// sequence. After reset and after every write of the delay register, a clearing
// pass zeroes every entry of the delay line, during which no input transfer takes
// place; configuration writes belong between items, while no item is in flight.
module feedback_echo_damped_unit #(
  parameter int DELAY_DEPTH = fed_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fed_in_if.sink                          in_ch,
  fed_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [fed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fed_pkg::CFG_W-1:0]       cfg_data
);
  import fed_pkg::*;

  localparam int AW  = $clog2(DELAY_DEPTH);
  // The position may stand one past the last entry until the next item wraps it.
  localparam int PW  = AW + 1;
  localparam int LW  = ((AW > CFG_W) ? AW : CFG_W) + 1;
  localparam int TW  = PROD_W - GAIN_SHIFT;
  localparam int DW  = TW + 1;
  localparam int ACW = SAMPLE_BITS + 17;
  localparam int LPW = ACW + 1 - LP_SHIFT;

  localparam logic [LW-1:0] LAST     = LW'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(DELAY_DEPTH - 1);

  localparam logic signed [DW-1:0] D_HI =
    {{(DW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [DW-1:0] D_LO = ~D_HI;

  localparam logic [PROD_W-1:0] P_HALF = PROD_W'(1) << (GAIN_SHIFT - 1);
  localparam logic [ACW:0]      L_HALF = (ACW+1)'(1) << (LP_SHIFT - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_GAIN  = 8'b0000_0100,
    S_PROD  = 8'b0000_1000,
    S_DIFF  = 8'b0001_0000,
    S_LP1   = 8'b0010_0000,
    S_LP2   = 8'b0100_0000,
    S_WB    = 8'b1000_0000
  } state_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [DW-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > D_HI) begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (v < D_LO) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] delay_r, gain_r, damp_r;

  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic signed [SAMPLE_BITS-1:0] lpm_r, lpm_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic signed [MOD_W-1:0]       mod_r, mod_nxt;
  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic signed [ACW-1:0]         acc_r, acc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  mul_req_t                  mreq;
  logic signed [PROD_W-1:0]  p_r;

  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;

  logic [LW-1:0]   dly_ext, limit;
  logic [PW-1:0]   pos_eff;
  logic [CFG_W-1:0] fb_c, d_c, omd, mod_off;

  logic [PROD_W-1:0]        t_sum;
  logic [TW-1:0]            term;
  logic signed [DW-1:0]     diff;
  logic signed [SAMPLE_BITS-1:0] val_w;
  logic [ACW:0]             l_sum;
  logic [LPW-1:0]           lp_raw;
  logic signed [SAMPLE_BITS-1:0] lp_w;

  // Position wrap against the delay length, capped at the storage depth.
  assign dly_ext = LW'(delay_r);
  assign limit   = (dly_ext > LAST) ? LAST : dly_ext;
  assign pos_eff = (LW'(pos_r) > limit) ? '0 : pos_r;

  assign fb_c    = (gain_r > ONE_Q15) ? ONE_Q15 : gain_r;
  assign d_c     = (damp_r > ONE_Q15) ? ONE_Q15 : damp_r;
  assign omd     = ONE_Q15 - d_c;
  // Adding one half of the range to a signed value flips its top bit.
  assign mod_off = {~mod_r[MOD_W-1], mod_r[MOD_W-2:0]};

  // Gain term rounded with halves upward, then the saturated difference.
  assign t_sum = p_r + P_HALF;
  assign term  = t_sum[PROD_W-1:GAIN_SHIFT];
  assign diff  = {{(DW-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r} - {term[TW-1], term};
  assign val_w = sat_smp(diff);

  // Low-pass: both weighted products summed, rounded and saturated.
  assign l_sum  = {acc_r[ACW-1], acc_r} + {p_r[ACW-1], p_r[ACW-1:0]} + L_HALF;
  assign lp_raw = l_sum[ACW:LP_SHIFT];
  assign lp_w   = sat_smp({{(DW-LPW){lp_raw[LPW-1]}}, lp_raw});

  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_WB);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_r : pos_r[AW-1:0];
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : lp_w;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    lpm_nxt       = lpm_r;
    x_nxt         = x_r;
    mod_nxt       = mod_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mreq          = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          x_nxt     = in_ch.sample_in;
          mod_nxt   = in_ch.feedback_mod;
          pos_nxt   = pos_eff;
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        mreq.en   = 1'b1;
        mreq.a    = {{(MUL_W-CFG_W){1'b0}}, fb_c};
        mreq.b    = {{(MUL_W-CFG_W){1'b0}}, mod_off};
        state_nxt = S_PROD;
      end
      S_PROD: begin
        mreq.en   = 1'b1;
        mreq.a    = {{(MUL_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
        mreq.b    = {1'b0, p_r[MUL_W-2:0]};
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        // Waits here only while the previous result has not been taken.
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt  = val_w;
          out_valid_nxt = 1'b1;
          val_nxt       = val_w;
          state_nxt     = S_LP1;
        end
      end
      S_LP1: begin
        mreq.en   = 1'b1;
        mreq.a    = {{(MUL_W-SAMPLE_BITS){val_r[SAMPLE_BITS-1]}}, val_r};
        mreq.b    = {{(MUL_W-CFG_W){1'b0}}, d_c};
        state_nxt = S_LP2;
      end
      S_LP2: begin
        mreq.en   = 1'b1;
        mreq.a    = {{(MUL_W-SAMPLE_BITS){lpm_r[SAMPLE_BITS-1]}}, lpm_r};
        mreq.b    = {{(MUL_W-CFG_W){1'b0}}, omd};
        acc_nxt   = p_r[ACW-1:0];
        state_nxt = S_WB;
      end
      S_WB: begin
        lpm_nxt   = lp_w;
        pos_nxt   = pos_r + 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    // A new delay length starts a fresh clearing pass of the delay line.
    if (cfg_we && (cfg_index == REG_DELAY)) begin
      state_nxt = S_CLEAR;
      clr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pos_r       <= '0;
      lpm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      lpm_r       <= lpm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    mod_r      <= mod_nxt;
    val_r      <= val_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
      gain_r  <= GAIN_RST;
      damp_r  <= DAMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY: delay_r <= cfg_data;
        REG_GAIN:  gain_r  <= cfg_data;
        REG_DAMP:  damp_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fed_mul u_mul (
    .clk (clk),
    .req (mreq),
    .p_r (p_r)
  );

  fed_ram #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (pos_eff[AW-1:0]),
    .rdata_r (rd_data)
  );

endmodule

`default_nettype wire

FILE: rtl/fed_chk.sv
// Port-level assertions of the damped feedback echo and their binding to the top level.
`default_nettype none

module fed_chk #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [SAMPLE_BITS-1:0]        out_data,
  input logic                          cfg_we,
  input logic [fed_pkg::CFG_IDX_W-1:0] cfg_index
);
  import fed_pkg::*;

  // The delay line is being cleared in the cycle after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready directly after reset");

  // A new delay length always starts a clearing pass.
  a_clear_on_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == REG_DELAY)) |=> !in_ready)
    else $error("input ready after a delay register write");

  // Each item occupies the sequencer, so input is not ready again directly after a transfer.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready in the cycle after an input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind feedback_echo_damped_unit fed_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fed_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.sample_out),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);

`default_nettype wire

FILE: tb/feedback_echo_damped_unit_tb.sv
// Self-checking testbench of the damped feedback echo, with a scoreboard that predicts each sample.

class echo_scoreboard #(int DEPTH = 256);
  logic signed [23:0] line_mem [DEPTH];
  int unsigned        pos;
  longint             lp_mem;
  logic [15:0]        delay_len;
  logic [15:0]        fb_gain;
  logic [15:0]        damp;
  logic signed [23:0] due_q [$];

  function new();
    foreach (line_mem[i]) line_mem[i] = '0;
    pos       = 0;
    lp_mem    = 0;
    delay_len = fed_pkg::DELAY_RST;
    fb_gain   = fed_pkg::GAIN_RST;
    damp      = fed_pkg::DAMP_RST;
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  function void reg_write(logic [fed_pkg::CFG_IDX_W-1:0] idx, logic [fed_pkg::CFG_W-1:0] data);
    case (idx)
      fed_pkg::REG_DELAY: begin
        delay_len = data;
        // The delay line is wiped; position and filter memory survive.
        foreach (line_mem[i]) line_mem[i] = '0;
      end
      fed_pkg::REG_GAIN: fb_gain = data;
      fed_pkg::REG_DAMP: damp = data;
      default: ;
    endcase
  endfunction

  function longint clip(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Rounds to nearest with halves towards plus infinity.
  function longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function void note_input(logic signed [23:0] x_in, logic signed [15:0] mod_in);
    longint      x;
    longint      m;
    longint      fb;
    longint      d;
    longint      one;
    longint      stored;
    longint      gain;
    longint      val;
    longint      lp;
    int unsigned lim;
    logic signed [23:0] val_w;
    x   = x_in;
    m   = mod_in;
    one = longint'(fed_pkg::ONE_Q15);
    lim = delay_len;
    if (lim > DEPTH - 1) lim = DEPTH - 1;
    if (pos > lim) pos = 0;
    fb = (longint'(fb_gain) > one) ? one : longint'(fb_gain);
    d  = (longint'(damp) > one) ? one : longint'(damp);
    stored = line_mem[pos];
    gain   = fb * (one + m);
    val    = clip(x - round_shift(stored * gain, fed_pkg::GAIN_SHIFT));
    lp     = clip(round_shift(val * d + lp_mem * (one - d), fed_pkg::LP_SHIFT));
    line_mem[pos] = lp[23:0];
    lp_mem = lp;
    pos++;
    val_w = val[23:0];
    due_q.push_back(val_w);
  endfunction

  function bit check_result(logic signed [23:0] got, output string msg);
    logic signed [23:0] want;
    if (due_q.size() == 0) begin
      msg = $sformatf("sample_out %0d arrived with nothing expected", got);
      return 0;
    end
    want = due_q.pop_front();
    if (got !== want) begin
      msg = $sformatf("sample_out got %0d expected %0d", got, want);
      return 0;
    end
    msg = "";
    return 1;
  endfunction
endclass

module feedback_echo_damped_unit_tb;
  import fed_pkg::*;

  // A small delay line keeps the clearing pass short and makes the delay limit reachable.
  localparam int TB_DEPTH       = 256;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 50;
  localparam int IDLE_PCT       = 28;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
  localparam logic signed [15:0] MOD_MAX    = 16'sh7FFF;
  localparam logic signed [15:0] MOD_MIN    = 16'sh8000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bit    tx_burst;
  bit    rx_burst;
  int    errors;
  int    stall_cycles;
  string note;

  echo_scoreboard #(TB_DEPTH) sb;

  fed_in_if  in_ch ();
  fed_out_if out_ch ();

  feedback_echo_damped_unit #(
    .DELAY_DEPTH(TB_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS_DEF)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("mismatch: %s", msg);
  endtask

  // Transfers on both channels are taken at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.sample_in, in_ch.feedback_mod);
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (!sb.check_result(out_ch.sample_out, note)) report_mismatch(note);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid === 1'b1 && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ch.ready = rx_burst ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.reg_write(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Lets every outstanding sample drain, plus the write-back that follows it.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(logic signed [23:0] s, logic signed [15:0] m);
    if (!tx_burst && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.sample_in    = s;
    in_ch.feedback_mod = m;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_delay();
    case ($urandom_range(3))
      0: return CFG_W'($urandom_range(0, 7));
      1: return CFG_W'($urandom_range(0, 300));
      2: return CFG_W'($urandom());
      default: begin
        case ($urandom_range(3))
          0: return 16'd0;
          1: return 16'(TB_DEPTH - 1);
          2: return 16'(TB_DEPTH);
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_q15();
    case ($urandom_range(3))
      0: return CFG_W'($urandom_range(0, 32768));
      1: return CFG_W'($urandom());
      2: return ONE_Q15;
      default: return CFG_W'($urandom_range(30000, 32768));
    endcase
  endfunction

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(5))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic signed [15:0] pick_mod();
    case ($urandom_range(7))
      0: return MOD_MAX;
      1: return MOD_MIN;
      2: return 16'sd0;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    errors             = 0;
    tx_burst           = 1'b0;
    rx_burst           = 1'b0;
    sb                 = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_in    = '0;
    in_ch.feedback_mod = '0;
    out_ch.ready       = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Short delay at unity gain, so stored extremes come back within a few samples.
    write_reg(REG_DELAY, 16'd2);
    write_reg(REG_GAIN, ONE_Q15);
    write_reg(REG_DAMP, ONE_Q15);
    send_item(SAMPLE_MAX, 16'sd0);
    send_item(SAMPLE_MIN, MOD_MAX);
    send_item(24'sd0, MOD_MIN);
    send_item(SAMPLE_MIN, MOD_MAX);
    send_item(SAMPLE_MAX, MOD_MAX);
    send_item(24'sd1, MOD_MIN);
    send_item(-24'sd1, 16'sd0);
    send_item(SAMPLE_MAX, MOD_MIN);

    // Gain and damping above one are clamped; an unknown index is ignored.
    settle();
    write_reg(REG_GAIN, 16'hFFFF);
    write_reg(REG_DAMP, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(SAMPLE_MIN, MOD_MAX);
    send_item(SAMPLE_MAX, MOD_MAX);
    send_item(24'sd12345, 16'sd0);
    send_item(SAMPLE_MAX, MOD_MAX);

    // Delay beyond the store, then zero gain and full damping.
    settle();
    write_reg(REG_DELAY, 16'hFFFF);
    write_reg(REG_GAIN, 16'd0);
    write_reg(REG_DAMP, 16'd0);
    send_item(SAMPLE_MAX, MOD_MAX);
    send_item(SAMPLE_MIN, MOD_MIN);
    send_item(24'sd0, 16'sd0);

    settle();
    write_reg(REG_DELAY, 16'(TB_DEPTH));
    write_reg(REG_GAIN, 16'd32767);
    write_reg(REG_DAMP, 16'd16384);
    send_item(SAMPLE_MAX, 16'sd0);
    send_item(SAMPLE_MIN, MOD_MAX);

    // Zero delay feeds the filter output straight back on the next sample.
    settle();
    write_reg(REG_DELAY, 16'd0);
    send_item(SAMPLE_MAX, MOD_MAX);
    send_item(SAMPLE_MIN, MOD_MAX);
    send_item(24'sd4096, MOD_MIN);
    send_item(SAMPLE_MAX, 16'sd0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(REG_DELAY, 16'd0);
          write_reg(REG_GAIN, 16'hFFFF);
          write_reg(REG_DAMP, 16'd0);
        end
        1: begin
          write_reg(REG_DELAY, 16'hFFFF);
          write_reg(REG_GAIN, 16'd0);
          write_reg(REG_DAMP, 16'hFFFF);
        end
        2: begin
          write_reg(REG_DELAY, 16'd1);
          write_reg(REG_GAIN, ONE_Q15);
          write_reg(REG_DAMP, ONE_Q15);
        end
        default: begin
          if ($urandom_range(1)) write_reg(REG_GAIN, pick_q15());
          if ($urandom_range(1)) write_reg(REG_DAMP, pick_q15());
          if ($urandom_range(3) == 0) write_reg(REG_UNUSED, CFG_W'($urandom()));
          write_reg(REG_DELAY, pick_delay());
        end
      endcase
      tx_burst = (p == 5);
      rx_burst = (p == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(pick_sample(), pick_mod());
    end

    tx_burst = 1'b0;
    rx_burst = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
